// ----- hdl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int LEAVES  = 1024;
    localparam int LVL_W   = $clog2(LEAVES);
    localparam int NODE_W  = LVL_W + 1;
    localparam int VAL_W   = LVL_W + 1;
    localparam int OFS_W   = 10;
    localparam int REQ_W   = 16;
    localparam int SIZE_W  = 11;
    localparam int NODES   = 2 * LEAVES;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_SIZE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NOT_HELD = 2'd2;

    typedef enum logic [1:0] {
        RES_ALLOC    = 2'd0,
        RES_SPAN     = 2'd1,
        RES_NO_SPACE = 2'd2,
        RES_NOT_HELD = 2'd3
    } res_code_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [REQ_W-1:0] req_size;
        logic [OFS_W-1:0] offset;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [OFS_W-1:0]  result_offset;
        logic [SIZE_W-1:0] block_size;
    } rsp_t;

    typedef struct packed {
        logic      load;
        logic      clr_step;
        logic      rd_root;
        logic      rd_left;
        logic      rd_node;
        logic      rd_lsib;
        logic      rd_rsib;
        logic      desc_step;
        logic      mark;
        logic      restore;
        logic      merge_wr;
        logic      up_step;
        logic      cap_size;
        logic      load_out;
        res_code_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_alloc;
        logic is_query;
        logic oversize;
        logic bad_cmd;
        logic root_short;
        logic span_is_want;
        logic desc_last;
        logic q_zero;
        logic at_root;
        logic parent_root;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- hdl/bba_dp.sv -----
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: tree memory, walk registers, result register.
// ----------------------------------------------------------------------------
module bba_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  bba_pkg::req_t    req_data,
    input  bba_pkg::dp_cmd_t cmd,
    output bba_pkg::dp_stat_t stat,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output bba_pkg::rsp_t    rsp_data
);

    logic [bba_pkg::VAL_W-1:0]  mem [bba_pkg::NODES];
    logic [bba_pkg::VAL_W-1:0]  q_reg;

    logic [bba_pkg::NODE_W-1:0] clr_addr_reg, clr_addr_next;
    logic [bba_pkg::VAL_W-1:0]  clr_val_reg, clr_val_next;

    logic [1:0]                 op_reg;
    logic                       oversize_reg;
    logic                       bad_reg;
    logic [bba_pkg::VAL_W-1:0]  want_reg;
    logic [bba_pkg::NODE_W-1:0] node_reg;
    logic [bba_pkg::VAL_W-1:0]  span_reg;
    logic [bba_pkg::OFS_W-1:0]  start_reg;
    logic [bba_pkg::VAL_W-1:0]  a_reg;
    logic [bba_pkg::SIZE_W-1:0] size_reg;

    logic                       out_valid_reg;
    bba_pkg::rsp_t              out_reg;

    logic [bba_pkg::REQ_W-1:0]  req_m1;
    logic [bba_pkg::VAL_W-1:0]  want_calc;
    logic                       go_right;
    logic [bba_pkg::VAL_W-1:0]  par_span;
    logic [bba_pkg::VAL_W:0]    pair_sum;
    logic [bba_pkg::VAL_W-1:0]  pair_max;
    logic [bba_pkg::VAL_W-1:0]  merge_val;
    logic                       rd_en;
    logic [bba_pkg::NODE_W-1:0] rd_addr;
    logic                       wr_en;
    logic [bba_pkg::NODE_W-1:0] wr_addr;
    logic [bba_pkg::VAL_W-1:0]  wr_data;

    always_comb
    begin
        req_m1 = (req_data.req_size == '0) ? '0 : req_data.req_size - 1'b1;
        want_calc = bba_pkg::VAL_W'(1);
        for (int i = 0; i < bba_pkg::LVL_W; i++)
        begin
            if ((req_m1 >> i) != '0)
            begin
                want_calc = bba_pkg::VAL_W'(1) << (i + 1);
            end
        end
    end

    assign go_right  = q_reg < want_reg;
    assign par_span  = span_reg << 1;
    assign pair_sum  = {1'b0, a_reg} + {1'b0, q_reg};
    assign pair_max  = (a_reg > q_reg) ? a_reg : q_reg;
    assign merge_val = (pair_sum == {1'b0, par_span}) ? par_span : pair_max;

    always_comb
    begin
        rd_en   = cmd.rd_root | cmd.rd_left | cmd.rd_node | cmd.rd_lsib | cmd.rd_rsib;
        rd_addr = node_reg;
        if (cmd.rd_root)
        begin
            rd_addr = bba_pkg::NODE_W'(1);
        end
        else if (cmd.rd_left || cmd.rd_lsib)
        begin
            rd_addr = cmd.rd_left ? {node_reg[bba_pkg::NODE_W-2:0], 1'b0}
                                  : {node_reg[bba_pkg::NODE_W-1:1], 1'b0};
        end
        else if (cmd.rd_rsib)
        begin
            rd_addr = {node_reg[bba_pkg::NODE_W-1:1], 1'b1};
        end
        wr_en   = cmd.clr_step | cmd.mark | cmd.restore | cmd.merge_wr;
        wr_addr = node_reg;
        wr_data = merge_val;
        if (cmd.clr_step)
        begin
            wr_addr = clr_addr_reg;
            wr_data = clr_val_reg;
        end
        else if (cmd.mark)
        begin
            wr_data = '0;
        end
        else if (cmd.restore)
        begin
            wr_data = span_reg;
        end
        else if (cmd.merge_wr)
        begin
            wr_addr = node_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        clr_addr_next = clr_addr_reg + 1'b1;
        clr_val_next  = clr_val_reg;
        if ((clr_addr_next & clr_addr_reg) == '0)
        begin
            clr_val_next = clr_val_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= bba_pkg::NODE_W'(1);
            clr_val_reg   <= bba_pkg::VAL_W'(bba_pkg::LEAVES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_next;
                clr_val_reg  <= clr_val_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= req_data.cmd;
            oversize_reg <= req_data.req_size > bba_pkg::REQ_W'(bba_pkg::LEAVES);
            bad_reg      <= (req_data.cmd != bba_pkg::CMD_FREE && req_data.cmd != bba_pkg::CMD_SIZE)
                            || ({1'b0, req_data.offset} >= 11'(bba_pkg::LEAVES));
            want_reg     <= want_calc;
            start_reg    <= '0;
            if (req_data.cmd == bba_pkg::CMD_ALLOC)
            begin
                node_reg <= bba_pkg::NODE_W'(1);
                span_reg <= bba_pkg::VAL_W'(bba_pkg::LEAVES);
            end
            else
            begin
                node_reg <= {1'b1, req_data.offset[bba_pkg::LVL_W-1:0]};
                span_reg <= bba_pkg::VAL_W'(1);
            end
        end
        if (cmd.desc_step)
        begin
            node_reg  <= {node_reg[bba_pkg::NODE_W-2:0], go_right};
            span_reg  <= span_reg >> 1;
            start_reg <= go_right ? start_reg + bba_pkg::OFS_W'(span_reg >> 1) : start_reg;
        end
        if (cmd.up_step)
        begin
            node_reg <= node_reg >> 1;
            span_reg <= par_span;
        end
        if (cmd.rd_rsib)
        begin
            a_reg <= q_reg;
        end
        if (cmd.cap_size)
        begin
            size_reg <= span_reg;
        end
        if (cmd.load_out)
        begin
            case (cmd.code)
                bba_pkg::RES_ALLOC:
                begin
                    out_reg <= '{bba_pkg::ST_OK, start_reg, want_reg};
                end
                bba_pkg::RES_SPAN:
                begin
                    out_reg <= '{bba_pkg::ST_OK, '0, size_reg};
                end
                bba_pkg::RES_NO_SPACE:
                begin
                    out_reg <= '{bba_pkg::ST_NO_SPACE, '0, '0};
                end
                default:
                begin
                    out_reg <= '{bba_pkg::ST_NOT_HELD, '0, '0};
                end
            endcase
        end
    end

    assign stat.clr_done     = clr_addr_reg == bba_pkg::NODE_W'(bba_pkg::NODES - 1);
    assign stat.is_alloc     = op_reg == bba_pkg::CMD_ALLOC;
    assign stat.is_query     = op_reg == bba_pkg::CMD_SIZE;
    assign stat.oversize     = oversize_reg;
    assign stat.bad_cmd      = bad_reg;
    assign stat.root_short   = q_reg < want_reg;
    assign stat.span_is_want = span_reg == want_reg;
    assign stat.desc_last    = (span_reg >> 1) == want_reg;
    assign stat.q_zero       = q_reg == '0;
    assign stat.at_root      = node_reg == bba_pkg::NODE_W'(1);
    assign stat.parent_root  = node_reg[bba_pkg::NODE_W-1:1] == (bba_pkg::NODE_W-1)'(1);
    assign stat.out_free     = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result register not marked valid after load");
    a_desc_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.desc_step |-> span_reg > want_reg)
        else $error("descent past the requested size");
    a_up_below_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.up_step |-> node_reg > bba_pkg::NODE_W'(1))
        else $error("climb above the root");

endmodule

// ----- hdl/bba_ctrl.sv -----
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller: sequences clearing, descent, climb and result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  bba_pkg::dp_stat_t stat,
    output bba_pkg::dp_cmd_t  cmd
);

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_DISP    = 13'b0000000000100,
        S_A_ROOT  = 13'b0000000001000,
        S_A_ROOTEV= 13'b0000000010000,
        S_A_RD    = 13'b0000000100000,
        S_A_EV    = 13'b0000001000000,
        S_A_MARK  = 13'b0000010000000,
        S_UP_L    = 13'b0000100000000,
        S_UP_R    = 13'b0001000000000,
        S_UP_W    = 13'b0010000000000,
        S_F_RD    = 13'b0100000000000,
        S_F_EV    = 13'b1000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    bba_pkg::res_code_t  code_reg, code_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        cmd_stall  = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (done_reg)
                begin
                    if (stat.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        done_next    = 1'b0;
                    end
                end
                else
                begin
                    cmd_stall = 1'b0;
                    if (cmd_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_DISP;
                    end
                end
            end
            S_DISP:
            begin
                if (stat.is_alloc)
                begin
                    if (stat.oversize)
                    begin
                        code_next  = bba_pkg::RES_NO_SPACE;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_root = 1'b1;
                        state_next  = S_A_ROOTEV;
                    end
                end
                else if (stat.bad_cmd)
                begin
                    code_next  = bba_pkg::RES_NOT_HELD;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_F_RD;
                end
            end
            S_A_ROOT:
            begin
                cmd.rd_root = 1'b1;
                state_next  = S_A_ROOTEV;
            end
            S_A_ROOTEV:
            begin
                if (stat.root_short)
                begin
                    code_next  = bba_pkg::RES_NO_SPACE;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.span_is_want)
                begin
                    state_next = S_A_MARK;
                end
                else
                begin
                    state_next = S_A_RD;
                end
            end
            S_A_RD:
            begin
                cmd.rd_left = 1'b1;
                state_next  = S_A_EV;
            end
            S_A_EV:
            begin
                cmd.desc_step = 1'b1;
                state_next    = stat.desc_last ? S_A_MARK : S_A_RD;
            end
            S_A_MARK:
            begin
                cmd.mark  = 1'b1;
                code_next = bba_pkg::RES_ALLOC;
                if (stat.at_root)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_UP_L;
                end
            end
            S_UP_L:
            begin
                cmd.rd_lsib = 1'b1;
                state_next  = S_UP_R;
            end
            S_UP_R:
            begin
                cmd.rd_rsib = 1'b1;
                state_next  = S_UP_W;
            end
            S_UP_W:
            begin
                cmd.merge_wr = 1'b1;
                cmd.up_step  = 1'b1;
                if (stat.parent_root)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_UP_L;
                end
            end
            S_F_RD:
            begin
                cmd.rd_node = 1'b1;
                state_next  = S_F_EV;
            end
            S_F_EV:
            begin
                if (stat.q_zero)
                begin
                    cmd.cap_size = 1'b1;
                    code_next    = bba_pkg::RES_SPAN;
                    if (stat.is_query || stat.at_root)
                    begin
                        cmd.restore = !stat.is_query;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cmd.restore = 1'b1;
                        state_next  = S_UP_L;
                    end
                end
                else if (stat.at_root)
                begin
                    code_next  = bba_pkg::RES_NOT_HELD;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.up_step = 1'b1;
                    state_next  = S_F_RD;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
            code_reg  <= bba_pkg::RES_NOT_HELD;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            code_reg  <= code_next;
        end
    end

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> cmd_stall)
        else $error("input taken while busy");
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_DISP)
        else $error("load did not lead to dispatch");
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !cmd.load && !cmd.load_out)
        else $error("activity during tree clear");

endmodule

// ----- hdl/buddy_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Binary buddy allocator over 1024 blocks with a free-run tree in memory.
//
//   channel  dir  handshake            beat
//   cmd      in   cmd_valid/cmd_stall  cmd, req_size, offset
//   rsp      out  rsp_valid/rsp_stall  status, result_offset, block_size
//
// After reset the tree is cleared while cmd_stall stays high. Allocate:
// reads the root, descends by reading left children, marks the found node,
// then climbs, writing each parent from its two children. Free and query
// climb from the leaf to the held node; free then restores it and climbs
// to the root the same way. One port of the tree memory sets the pace.
// A stalled rsp beat is held while the next cmd is taken.
// ----------------------------------------------------------------------------
module buddy_block_allocator_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  bba_pkg::req_t cmd_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bba_pkg::rsp_t rsp_data
);

    bba_pkg::dp_cmd_t  dcmd;
    bba_pkg::dp_stat_t dstat;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (dstat),
        .cmd       (dcmd)
    );

    bba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (cmd_data),
        .cmd       (dcmd),
        .stat      (dstat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

// ----- verif/bba_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bba_checker
// Watches the cmd and rsp channels of the buddy block allocator, keeps its
// own free-run tree, works out the response to every accepted command and
// compares each response beat field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module bba_checker
    import bba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    input  logic  cmd_stall,
    input  req_t  cmd_data,
    input  logic  rsp_valid,
    input  logic  rsp_stall,
    input  rsp_t  rsp_data,
    output int    errors,
    output int    pending
);

    localparam int TREE_NODES = 2 * LEAVES - 1;

    logic [SIZE_W-1:0] free_run [0:TREE_NODES-1];
    rsp_t              expected_rsps [$];

    assign pending = expected_rsps.size();

    function automatic void clear_tree();
        int span;
        span = 2 * LEAVES;
        for (int i = 0; i < TREE_NODES; i++)
        begin
            if (((i + 1) & i) == 0)
                span = span >> 1;
            free_run[i] = span[SIZE_W-1:0];
        end
    endfunction

    function automatic rsp_t apply_cmd(req_t r);
        int   want;
        int   n;
        int   span;
        int   l;
        int   rr;
        bit   found;
        rsp_t o;
        o = '0;
        if (r.cmd == CMD_ALLOC)
        begin
            want = 1;
            while (want < int'(r.req_size))
                want = want << 1;
            if (want > LEAVES || int'(free_run[0]) < want)
            begin
                o.status = ST_NO_SPACE;
                return o;
            end
            n = 0;
            for (span = LEAVES; span != want; span = span >> 1)
                n = (int'(free_run[2 * n + 1]) >= want) ? 2 * n + 1 : 2 * n + 2;
            free_run[n] = '0;
            o.result_offset = OFS_W'((n + 1) * span - LEAVES);
            o.block_size    = SIZE_W'(want);
            while (n != 0)
            begin
                n = (n + 1) / 2 - 1;
                l  = free_run[2 * n + 1];
                rr = free_run[2 * n + 2];
                free_run[n] = SIZE_W'((l > rr) ? l : rr);
            end
            return o;
        end
        if (r.cmd != CMD_FREE && r.cmd != CMD_SIZE)
        begin
            o.status = ST_NOT_HELD;
            return o;
        end
        n = int'(r.offset) + LEAVES - 1;
        span = 1;
        found = 1;
        while (free_run[n] != 0)
        begin
            if (n == 0)
            begin
                found = 0;
                break;
            end
            n = (n + 1) / 2 - 1;
            span = span << 1;
        end
        if (!found)
        begin
            o.status = ST_NOT_HELD;
            return o;
        end
        o.block_size = SIZE_W'(span);
        if (r.cmd == CMD_FREE)
        begin
            free_run[n] = SIZE_W'(span);
            while (n != 0)
            begin
                n = (n + 1) / 2 - 1;
                span = span << 1;
                l  = free_run[2 * n + 1];
                rr = free_run[2 * n + 2];
                free_run[n] = SIZE_W'((l + rr == span) ? span : ((l > rr) ? l : rr));
            end
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_tree();
            expected_rsps.delete();
            errors <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected rsp beat: %p", rsp_data);
                    errors <= errors + 1;
                end
                else
                begin
                    rsp_t want_rsp;
                    want_rsp = expected_rsps.pop_front();
                    if (rsp_data.status !== want_rsp.status
                        || rsp_data.result_offset !== want_rsp.result_offset
                        || rsp_data.block_size !== want_rsp.block_size)
                    begin
                        if (errors < 10)
                            $display({"rsp mismatch: expected st=%0d ofs=%0d sz=%0d,",
                                      " got st=%0d ofs=%0d sz=%0d"},
                                     want_rsp.status, want_rsp.result_offset,
                                     want_rsp.block_size, rsp_data.status,
                                     rsp_data.result_offset, rsp_data.block_size);
                        errors <= errors + 1;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
                expected_rsps.push_back(apply_cmd(cmd_data));
        end
    end

endmodule

// ----- verif/buddy_block_allocator_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_top_test
// Drives directed and random allocate, free and size commands into the buddy
// allocator with random gaps and response stalls; the checker beside the
// block predicts and compares every response.
// ----------------------------------------------------------------------------
module buddy_block_allocator_top_test;
    import bba_pkg::*;

    localparam logic [1:0] CMD_BAD = 2'd3;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    req_t cmd_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;
    int   errors;
    int   pending;
    bit   quiet;

    logic [1:0]       issued_cmds [$];
    logic [OFS_W-1:0] live_offsets [$];

    buddy_block_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    bba_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #40ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // track live allocations so that frees mostly hit something
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall && issued_cmds.size() > 0)
        begin
            logic [1:0] c;
            c = issued_cmds.pop_front();
            if (c == CMD_ALLOC && rsp_data.status == ST_OK)
                live_offsets.push_back(rsp_data.result_offset);
        end
    end

    task automatic send(input logic [1:0] c, input logic [REQ_W-1:0] sz,
                        input logic [OFS_W-1:0] ofs);
        int gap;
        cmd_valid <= 1'b1;
        cmd_data  <= '{cmd: c, req_size: sz, offset: ofs};
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
        issued_cmds.push_back(c);
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random();
        int  pick;
        int  idx;
        logic [OFS_W-1:0] ofs;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            if ($urandom_range(0, 9) < 7)
                send(CMD_ALLOC, REQ_W'($urandom_range(0, 16)), OFS_W'($urandom));
            else if ($urandom_range(0, 3) != 0)
                send(CMD_ALLOC, REQ_W'($urandom_range(0, 1024)), OFS_W'($urandom));
            else
                send(CMD_ALLOC, REQ_W'($urandom), OFS_W'($urandom));
        end
        else if (pick < 95 && live_offsets.size() > 0 && $urandom_range(0, 9) < 8)
        begin
            idx = $urandom_range(0, live_offsets.size() - 1);
            ofs = live_offsets[idx];
            if ($urandom_range(0, 3) == 0)
                ofs = ofs | OFS_W'($urandom_range(0, 3));
            if (pick < 80)
            begin
                live_offsets.delete(idx);
                send(CMD_FREE, REQ_W'($urandom), ofs);
            end
            else
                send(CMD_SIZE, REQ_W'($urandom), ofs);
        end
        else if (pick < 80)
            send(CMD_FREE, REQ_W'($urandom), OFS_W'($urandom));
        else if (pick < 95)
            send(CMD_SIZE, REQ_W'($urandom), OFS_W'($urandom));
        else
            send(CMD_BAD, REQ_W'($urandom), OFS_W'($urandom));
    endtask

    // response side stalls
    initial
    begin
        int n;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 15);
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0))
                @(posedge clk);
        end
    end

    initial
    begin
        int waited;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd_data  <= '0;
        quiet     = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(CMD_ALLOC, 16'd1024, 10'd0);
        send(CMD_ALLOC, 16'd0, 10'd0);
        send(CMD_SIZE, 16'd0, 10'd700);
        send(CMD_FREE, 16'd0, 10'd1023);
        send(CMD_FREE, 16'd0, 10'd0);
        send(CMD_ALLOC, 16'd65535, 10'd1023);
        send(CMD_ALLOC, 16'd1025, 10'd0);
        send(CMD_ALLOC, 16'd0, 10'd0);
        send(CMD_ALLOC, 16'd3, 10'd0);
        send(CMD_ALLOC, 16'd512, 10'd0);
        send(CMD_ALLOC, 16'd1, 10'd0);
        send(CMD_SIZE, 16'd0, 10'd5);
        send(CMD_SIZE, 16'd0, 10'd1023);
        send(CMD_FREE, 16'd0, 10'd6);
        send(CMD_BAD, 16'hFFFF, 10'h3FF);
        send(CMD_FREE, 16'd0, 10'd512);
        send(CMD_FREE, 16'd0, 10'd0);
        send(CMD_FREE, 16'd0, 10'd8);
        send(CMD_SIZE, 16'd0, 10'd0);
        send(CMD_ALLOC, 16'd1024, 10'd0);
        send(CMD_FREE, 16'd0, 10'd1000);

        for (int i = 0; i < 1850; i++)
        begin
            quiet = ((i / 150) % 4) == 3;
            if (i == 900)
            begin
                cmd_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            send_random();
        end
        cmd_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/bba_pkg.sv
hdl/bba_dp.sv
hdl/bba_ctrl.sv
hdl/buddy_block_allocator_top.sv
verif/bba_checker.sv
verif/buddy_block_allocator_top_test.sv
